/* rtl/rcm_pkg.sv */
// Package for the register cache mailbox: mode codes, configuration indexes,
// low-address kinds and the shared item and cache-entry types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package rcm_pkg;

  localparam int MODE_W    = 3;
  localparam int WORD_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_BUS_READ     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BUS_WRITE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UPDATE       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POLL         = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SET_WRITABLE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SET_FAIL     = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SET_FAIL_RSV = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUILD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_MASK = 2'd2;

  // What a read below the cache window returns.
  localparam logic [2:0] LOW_NONE  = 3'd0;
  localparam logic [2:0] LOW_BOARD = 3'd1;
  localparam logic [2:0] LOW_BUILD = 3'd2;
  localparam logic [2:0] LOW_FAIL  = 3'd3;
  localparam logic [2:0] LOW_ZERO  = 3'd4;

  // Queue between the front and back parts.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              hit;
    logic [2:0]        low_kind;
    logic [WORD_W-1:0] data;
    logic              flag;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] cached;
    logic [WORD_W-1:0] pending;
    logic              writable;
    logic              written;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/rcm_in_if.sv */
// Input channel of the register cache mailbox: valid, ready and one access.
// Depends on rcm_pkg for field widths.
`default_nettype none

interface rcm_in_if import rcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [WORD_W-1:0] address;
  logic [WORD_W-1:0] data;
  logic              writable_flag;

  modport source (output valid, mode, address, data, writable_flag, input ready);
  modport sink (input valid, mode, address, data, writable_flag, output ready);
endinterface

`default_nettype wire

/* rtl/rcm_out_if.sv */
// Result channel of the register cache mailbox: valid, ready, ack and data.
// Depends on rcm_pkg for field widths.
`default_nettype none

interface rcm_out_if import rcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ack;
  logic [WORD_W-1:0] read_data;

  modport source (output valid, ack, read_data, input ready);
  modport sink (input valid, ack, read_data, output ready);
endinterface

`default_nettype wire

/* rtl/rcm_cfg_if.sv */
// Configuration write channel: valid, ready, register index and write data.
// Depends on rcm_pkg for field widths.
`default_nettype none

interface rcm_cfg_if import rcm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [WORD_W-1:0]    wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

/* rtl/rcm_front.sv */
// Front part: accepts accesses, decodes the address window and low-address
// kind, and holds decoded items in a two-entry queue. Uses rcm_pkg, rcm_in_if.
`default_nettype none

module rcm_front import rcm_pkg::*; #(
  parameter int CACHE_ENTRIES    = 32,
  parameter int CACHE_BASE       = 16,
  parameter int INTA_ADDRESS     = 1,
  parameter int BOARD_ID_ADDRESS = 2,
  parameter int FAIL_ADDRESS     = 4,
  parameter int SWITCHES_ADDRESS = 5,
  parameter int SLOT_W           = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rcm_in_if.sink                 in_ch,
  input  wire logic              clear_busy,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output item_t                  q_item,
  output logic [SLOT_W-1:0]      q_slot
);

  item_t             q_item_r [Q_DEPTH];
  logic [SLOT_W-1:0] q_slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  logic              push, pop;
  logic [WORD_W:0]   offset;
  item_t             dec_item;
  logic [SLOT_W-1:0] dec_slot;

  always_comb begin
    offset = {1'b0, in_ch.address} - (WORD_W+1)'(CACHE_BASE);
    dec_item.mode = in_ch.mode;
    dec_item.hit  = !offset[WORD_W] && (offset < (WORD_W+1)'(CACHE_ENTRIES));
    dec_item.data = in_ch.data;
    dec_item.flag = in_ch.writable_flag;
    dec_slot      = offset[SLOT_W-1:0];
    // Coinciding low addresses resolve in this order, first match wins.
    if (in_ch.address == '0 || in_ch.address == WORD_W'(INTA_ADDRESS)) begin
      dec_item.low_kind = LOW_NONE;
    end else if (in_ch.address == WORD_W'(BOARD_ID_ADDRESS)) begin
      dec_item.low_kind = LOW_BOARD;
    end else if (in_ch.address == WORD_W'(BOARD_ID_ADDRESS + 1)) begin
      dec_item.low_kind = LOW_BUILD;
    end else if (in_ch.address == WORD_W'(FAIL_ADDRESS)) begin
      dec_item.low_kind = LOW_FAIL;
    end else if (in_ch.address == WORD_W'(SWITCHES_ADDRESS)) begin
      dec_item.low_kind = LOW_ZERO;
    end else begin
      dec_item.low_kind = LOW_NONE;
    end
  end

  assign in_ch.ready = (cnt_r != Q_CNT_W'(Q_DEPTH)) && !clear_busy;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_valid && q_ready;
  assign q_item      = q_item_r[rd_ptr_r];
  assign q_slot      = q_slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_item_r[wr_ptr_r] <= dec_item;
      q_slot_r[wr_ptr_r] <= dec_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/rcm_back.sv */
// Back part: cache memory with read-modify-write, fail word, configuration
// registers and the result register. Uses rcm_pkg, rcm_out_if, rcm_cfg_if.
`default_nettype none

module rcm_back import rcm_pkg::*; #(
  parameter int CACHE_ENTRIES = 32,
  parameter int SLOT_W        = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rcm_out_if.source              out_ch,
  rcm_cfg_if.sink                cfg_ch,
  output logic                   clear_busy,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire item_t             q_item,
  input  wire logic [SLOT_W-1:0] q_slot
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  entry_t mem [CACHE_ENTRIES];

  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] clr_r;
  item_t             ex_item_r;
  logic [SLOT_W-1:0] ex_slot_r;
  entry_t            rd_word_r;
  logic [WORD_W-1:0] board_id_r, build_r, fail_mask_r, fail_word_r, fail_nxt;
  logic              out_valid_r, out_ack_r;
  logic [WORD_W-1:0] out_data_r;

  entry_t            w_nxt;
  logic              ex_ack, ex_wr, ex_go, cfg_wr;
  logic [WORD_W-1:0] ex_rd;

  assign clear_busy = (state_r == ST_CLEAR);
  assign q_ready    = (state_r == ST_IDLE);
  assign ex_go      = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr     = cfg_ch.valid;

  always_comb begin
    w_nxt    = rd_word_r;
    ex_ack   = 1'b0;
    ex_wr    = 1'b0;
    ex_rd    = '0;
    fail_nxt = fail_word_r;
    case (ex_item_r.mode)
      MODE_BUS_READ: begin
        if (ex_item_r.hit) begin
          ex_ack = 1'b1;
          ex_rd  = rd_word_r.cached;
        end else begin
          case (ex_item_r.low_kind)
            LOW_BOARD: begin ex_ack = 1'b1; ex_rd = board_id_r;  end
            LOW_BUILD: begin ex_ack = 1'b1; ex_rd = build_r;     end
            LOW_FAIL:  begin ex_ack = 1'b1; ex_rd = fail_word_r; end
            LOW_ZERO:  begin ex_ack = 1'b1; end
            default:   begin end
          endcase
        end
      end
      MODE_BUS_WRITE: begin
        if (ex_item_r.hit && rd_word_r.writable) begin
          w_nxt.pending = ex_item_r.data;
          w_nxt.written = 1'b1;
          ex_ack = 1'b1;
          ex_wr  = 1'b1;
        end
      end
      MODE_UPDATE: begin
        if (ex_item_r.hit) begin
          w_nxt.cached = ex_item_r.data;
          ex_ack = 1'b1;
          ex_wr  = 1'b1;
        end
      end
      MODE_POLL: begin
        if (ex_item_r.hit && rd_word_r.written) begin
          ex_rd = rd_word_r.pending;
          w_nxt.written = 1'b0;
          ex_ack = 1'b1;
          ex_wr  = 1'b1;
        end
      end
      MODE_SET_WRITABLE: begin
        if (ex_item_r.hit) begin
          w_nxt.writable = ex_item_r.flag;
          ex_ack = 1'b1;
          ex_wr  = 1'b1;
        end
      end
      MODE_SET_FAIL: begin
        fail_nxt = (fail_word_r & fail_mask_r) | (ex_item_r.data & ~fail_mask_r);
        ex_ack   = 1'b1;
      end
      MODE_SET_FAIL_RSV: begin
        fail_nxt = (fail_word_r & ~fail_mask_r) | (ex_item_r.data & fail_mask_r);
        ex_ack   = 1'b1;
      end
      default: begin end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == SLOT_W'(CACHE_ENTRIES - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (q_valid) state_nxt = ST_EXEC;
      ST_EXEC:  if (ex_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // Single-port style memory: the clearing pass, execute writes and the
  // read at queue pop never fall in the same cycle.
  always_ff @(posedge clk) begin
    if (clear_busy) begin
      mem[clr_r] <= '0;
    end else if (ex_go && ex_wr) begin
      mem[ex_slot_r] <= w_nxt;
    end
    if (q_ready && q_valid) begin
      rd_word_r <= mem[q_slot];
      ex_item_r <= q_item;
      ex_slot_r <= q_slot;
    end
    if (ex_go) begin
      out_ack_r  <= ex_ack;
      out_data_r <= ex_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      board_id_r  <= '0;
      build_r     <= '0;
      fail_mask_r <= '0;
      fail_word_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clear_busy) clr_r <= clr_r + 1'b1;
      if (ex_go) begin
        out_valid_r <= 1'b1;
        fail_word_r <= fail_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        case (cfg_ch.reg_index)
          CFG_BOARD_ID:  board_id_r  <= cfg_ch.wdata;
          CFG_BUILD:     build_r     <= cfg_ch.wdata;
          CFG_FAIL_MASK: fail_mask_r <= cfg_ch.wdata;
          default:       begin end
        endcase
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.ack       = out_ack_r;
  assign out_ch.read_data = out_data_r;

endmodule

`default_nettype wire

/* rtl/register_cache_mailbox_unit.sv */
// Register cache mailbox, top level: a bus-side register cache with a
// write mailbox, pending-write marks and a split fail word.
// Channels: in_ch takes one access per beat (mode, address, data,
// writable_flag); out_ch returns one beat per access (ack, read_data);
// cfg_ch writes board_id (0), build_number (1) and fail_reserved_mask (2)
// and is always ready.
// The front part decodes each access into a two-entry queue. The back part
// reads the addressed cache entry when it takes an access from the queue
// and then, once out_ch can take a result, modifies the entry, writes it back
// and loads the result register; it takes no new access from the queue until
// the current one is done, so the cache memory's read-modify-write sets the
// sustained rate.
// After reset the cache memory is cleared one entry per cycle, from entry 0
// up to entry CACHE_ENTRIES-1; in_ch is not ready during that pass.
// When out_ch stalls, the result is held, the back part waits and the queue
// keeps accepting until it is full.
// Depends on rcm_pkg, the three channel interfaces, rcm_front and rcm_back.
`default_nettype none

module register_cache_mailbox_unit import rcm_pkg::*; #(
  parameter int CACHE_ENTRIES    = 32,
  parameter int CACHE_BASE       = 16,
  parameter int INTA_ADDRESS     = 1,
  parameter int BOARD_ID_ADDRESS = 2,
  parameter int FAIL_ADDRESS     = 4,
  parameter int SWITCHES_ADDRESS = 5
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rcm_in_if.sink    in_ch,
  rcm_out_if.source out_ch,
  rcm_cfg_if.sink   cfg_ch
);

  localparam int SLOT_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  logic              clear_busy;
  logic              q_valid, q_ready;
  item_t             q_item;
  logic [SLOT_W-1:0] q_slot;

  rcm_front #(
    .CACHE_ENTRIES    (CACHE_ENTRIES),
    .CACHE_BASE       (CACHE_BASE),
    .INTA_ADDRESS     (INTA_ADDRESS),
    .BOARD_ID_ADDRESS (BOARD_ID_ADDRESS),
    .FAIL_ADDRESS     (FAIL_ADDRESS),
    .SWITCHES_ADDRESS (SWITCHES_ADDRESS),
    .SLOT_W           (SLOT_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .clear_busy (clear_busy),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .q_slot     (q_slot)
  );

  rcm_back #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .SLOT_W        (SLOT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .clear_busy (clear_busy),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .q_slot     (q_slot)
  );

  // No beat is taken while the cache memory is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !in_ch.ready)
    else $error("input accepted during the clearing pass");

  // A refused access always carries a zero word.
  a_nack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ack) |-> (out_ch.read_data == '0))
    else $error("nonzero read data with ack low");

  // The back part never takes from the queue during the clearing pass.
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !q_ready)
    else $error("queue popped during the clearing pass");

  // A beat taken from an empty queue would invent a result.
  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    (q_ready && !q_valid) |=> !(out_ch.valid && !$past(out_ch.valid) && !$past(q_valid)))
    else $error("result produced without a queued access");

endmodule

`default_nettype wire
